// ===== rtl/c6502_pkg.sv =====
// ----------------------------------------------------------------------------
// c6502_pkg
// Shared types and constants for the cycle-exact 6502 subset core.
// ----------------------------------------------------------------------------
`default_nettype none
package c6502_pkg;
  localparam logic [3:0] M_NONE = 4'd0;
  localparam logic [3:0] M_IMM  = 4'd1;
  localparam logic [3:0] M_ZP   = 4'd2;
  localparam logic [3:0] M_ZPX  = 4'd3;
  localparam logic [3:0] M_ZPY  = 4'd4;
  localparam logic [3:0] M_ABS  = 4'd5;
  localparam logic [3:0] M_ABX  = 4'd6;
  localparam logic [3:0] M_ABY  = 4'd7;
  localparam logic [3:0] M_INDX = 4'd8;
  localparam logic [3:0] M_INDY = 4'd9;
  localparam logic [3:0] M_IMPL = 4'd10;
  localparam logic [3:0] M_JABS = 4'd11;
  localparam logic [3:0] M_JIND = 4'd12;

  localparam logic [4:0] OP_LDA = 5'd0;
  localparam logic [4:0] OP_LDX = 5'd1;
  localparam logic [4:0] OP_LDY = 5'd2;
  localparam logic [4:0] OP_AND = 5'd3;
  localparam logic [4:0] OP_ORA = 5'd4;
  localparam logic [4:0] OP_EOR = 5'd5;
  localparam logic [4:0] OP_CMP = 5'd6;
  localparam logic [4:0] OP_CPX = 5'd7;
  localparam logic [4:0] OP_CPY = 5'd8;
  localparam logic [4:0] OP_ADC = 5'd9;
  localparam logic [4:0] OP_SBC = 5'd10;
  localparam logic [4:0] OP_STA = 5'd11;
  localparam logic [4:0] OP_STX = 5'd12;
  localparam logic [4:0] OP_STY = 5'd13;
  localparam logic [4:0] OP_TAX = 5'd14;
  localparam logic [4:0] OP_TAY = 5'd15;
  localparam logic [4:0] OP_TXA = 5'd16;
  localparam logic [4:0] OP_TYA = 5'd17;
  localparam logic [4:0] OP_TSX = 5'd18;
  localparam logic [4:0] OP_TXS = 5'd19;
  localparam logic [4:0] OP_NOP = 5'd20;
  localparam logic [4:0] OP_JMP = 5'd21;

  localparam logic [2:0] CFG_PC     = 3'd0;
  localparam logic [2:0] CFG_ACC    = 3'd1;
  localparam logic [2:0] CFG_X      = 3'd2;
  localparam logic [2:0] CFG_Y      = 3'd3;
  localparam logic [2:0] CFG_SP     = 3'd4;
  localparam logic [2:0] CFG_STATUS = 3'd5;

  localparam logic [7:0] F_C = 8'h01;
  localparam logic [7:0] F_Z = 8'h02;
  localparam logic [7:0] F_I = 8'h04;
  localparam logic [7:0] F_D = 8'h08;
  localparam logic [7:0] F_V = 8'h40;
  localparam logic [7:0] F_N = 8'h80;

  typedef struct packed {
    logic [3:0] mode;
    logic [4:0] op;
  } dec_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } regs_t;

  function automatic dec_t decode(input logic [7:0] opc);
    dec_t d;
    d.mode = M_NONE;
    d.op   = OP_NOP;
    if (opc[1:0] == 2'b01) begin
      if (opc != 8'h89) begin
        case (opc[7:5])
          3'd0: d.op = OP_ORA;
          3'd1: d.op = OP_AND;
          3'd2: d.op = OP_EOR;
          3'd3: d.op = OP_ADC;
          3'd4: d.op = OP_STA;
          3'd5: d.op = OP_LDA;
          3'd6: d.op = OP_CMP;
          default: d.op = OP_SBC;
        endcase
        case (opc[4:2])
          3'd0: d.mode = M_INDX;
          3'd1: d.mode = M_ZP;
          3'd2: d.mode = M_IMM;
          3'd3: d.mode = M_ABS;
          3'd4: d.mode = M_INDY;
          3'd5: d.mode = M_ZPX;
          3'd6: d.mode = M_ABY;
          default: d.mode = M_ABX;
        endcase
      end
    end else begin
      unique case (opc)
        8'hA2: begin d.op = OP_LDX; d.mode = M_IMM; end
        8'hA6: begin d.op = OP_LDX; d.mode = M_ZP; end
        8'hB6: begin d.op = OP_LDX; d.mode = M_ZPY; end
        8'hAE: begin d.op = OP_LDX; d.mode = M_ABS; end
        8'hBE: begin d.op = OP_LDX; d.mode = M_ABY; end
        8'hA0: begin d.op = OP_LDY; d.mode = M_IMM; end
        8'hA4: begin d.op = OP_LDY; d.mode = M_ZP; end
        8'hB4: begin d.op = OP_LDY; d.mode = M_ZPX; end
        8'hAC: begin d.op = OP_LDY; d.mode = M_ABS; end
        8'hBC: begin d.op = OP_LDY; d.mode = M_ABX; end
        8'h86: begin d.op = OP_STX; d.mode = M_ZP; end
        8'h96: begin d.op = OP_STX; d.mode = M_ZPY; end
        8'h8E: begin d.op = OP_STX; d.mode = M_ABS; end
        8'h84: begin d.op = OP_STY; d.mode = M_ZP; end
        8'h94: begin d.op = OP_STY; d.mode = M_ZPX; end
        8'h8C: begin d.op = OP_STY; d.mode = M_ABS; end
        8'hE0: begin d.op = OP_CPX; d.mode = M_IMM; end
        8'hE4: begin d.op = OP_CPX; d.mode = M_ZP; end
        8'hEC: begin d.op = OP_CPX; d.mode = M_ABS; end
        8'hC0: begin d.op = OP_CPY; d.mode = M_IMM; end
        8'hC4: begin d.op = OP_CPY; d.mode = M_ZP; end
        8'hCC: begin d.op = OP_CPY; d.mode = M_ABS; end
        8'hAA: begin d.op = OP_TAX; d.mode = M_IMPL; end
        8'hA8: begin d.op = OP_TAY; d.mode = M_IMPL; end
        8'h8A: begin d.op = OP_TXA; d.mode = M_IMPL; end
        8'h98: begin d.op = OP_TYA; d.mode = M_IMPL; end
        8'hBA: begin d.op = OP_TSX; d.mode = M_IMPL; end
        8'h9A: begin d.op = OP_TXS; d.mode = M_IMPL; end
        8'hEA: begin d.op = OP_NOP; d.mode = M_IMPL; end
        8'h4C: begin d.op = OP_JMP; d.mode = M_JABS; end
        8'h6C: begin d.op = OP_JMP; d.mode = M_JIND; end
        default: d.mode = M_NONE;
      endcase
    end
    return d;
  endfunction

  function automatic logic is_store(input logic [4:0] op);
    return (op == OP_STA) || (op == OP_STX) || (op == OP_STY);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/c6502_alu.sv =====
// ----------------------------------------------------------------------------
// c6502_alu
// Register and flag update of one operation on an operand byte.
// ----------------------------------------------------------------------------
`default_nettype none
module c6502_alu (
  input  wire logic [4:0]      op,
  input  wire logic [7:0]      m,
  input  var  c6502_pkg::regs_t regs_in,
  output c6502_pkg::regs_t     regs_out
);
  logic [7:0] a;
  logic [7:0] p;
  logic       cin;
  logic [4:0] lo;
  logic [9:0] hi;
  logic [8:0] sum;
  logic [8:0] cmpd;
  logic [7:0] cr;
  logic signed [7:0] slo;
  logic signed [9:0] shi;
  logic [8:0] bsum;

  always_comb begin
    a   = regs_in.acc;
    p   = regs_in.p;
    cin = p[0];
    regs_out = regs_in;
    lo  = '0;
    hi  = '0;
    sum = '0;
    cmpd = '0;
    cr  = '0;
    slo = '0;
    shi = '0;
    bsum = '0;
    case (op)
      c6502_pkg::OP_LDA: begin regs_out.acc = m; cr = m; end
      c6502_pkg::OP_LDX: begin regs_out.x = m; cr = m; end
      c6502_pkg::OP_LDY: begin regs_out.y = m; cr = m; end
      c6502_pkg::OP_AND: begin regs_out.acc = a & m; cr = a & m; end
      c6502_pkg::OP_ORA: begin regs_out.acc = a | m; cr = a | m; end
      c6502_pkg::OP_EOR: begin regs_out.acc = a ^ m; cr = a ^ m; end
      c6502_pkg::OP_TAX: begin regs_out.x = a; cr = a; end
      c6502_pkg::OP_TAY: begin regs_out.y = a; cr = a; end
      c6502_pkg::OP_TXA: begin regs_out.acc = regs_in.x; cr = regs_in.x; end
      c6502_pkg::OP_TYA: begin regs_out.acc = regs_in.y; cr = regs_in.y; end
      c6502_pkg::OP_TSX: begin regs_out.x = regs_in.sp; cr = regs_in.sp; end
      c6502_pkg::OP_TXS: regs_out.sp = regs_in.x;
      default: ;
    endcase
    case (op)
      c6502_pkg::OP_LDA, c6502_pkg::OP_LDX, c6502_pkg::OP_LDY, c6502_pkg::OP_AND,
      c6502_pkg::OP_ORA, c6502_pkg::OP_EOR, c6502_pkg::OP_TAX, c6502_pkg::OP_TAY,
      c6502_pkg::OP_TXA, c6502_pkg::OP_TYA, c6502_pkg::OP_TSX: begin
        regs_out.p[1] = (cr == 8'h00);
        regs_out.p[7] = cr[7];
      end
      c6502_pkg::OP_CMP, c6502_pkg::OP_CPX, c6502_pkg::OP_CPY: begin
        cr = (op == c6502_pkg::OP_CMP) ? a : ((op == c6502_pkg::OP_CPX) ? regs_in.x : regs_in.y);
        cmpd = {1'b0, cr} - {1'b0, m};
        regs_out.p[0] = ~cmpd[8];
        regs_out.p[1] = (cmpd[7:0] == 8'h00);
        regs_out.p[7] = cmpd[7];
      end
      c6502_pkg::OP_ADC: begin
        sum = {1'b0, a} + {1'b0, m} + {8'd0, cin};
        if (p[3]) begin
          regs_out.p[1] = (sum[7:0] == 8'h00);
          lo = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'd0, cin};
          if (lo >= 5'h0A) lo = {1'b0, 4'(lo[3:0] + 4'h6)} + 5'h10;
          hi = {2'b0, a[7:4], 4'h0} + {2'b0, m[7:4], 4'h0} + {5'd0, lo};
          regs_out.p[7] = hi[7];
          regs_out.p[6] = ~(a[7] ^ m[7]) & (a[7] ^ hi[7]);
          if (hi >= 10'h0A0) hi = hi + 10'h060;
          regs_out.p[0] = hi[9] | hi[8];
          regs_out.acc = hi[7:0];
        end else begin
          regs_out.p[0] = sum[8];
          regs_out.p[6] = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
          regs_out.acc = sum[7:0];
          regs_out.p[1] = (sum[7:0] == 8'h00);
          regs_out.p[7] = sum[7];
        end
      end
      c6502_pkg::OP_SBC: begin
        bsum = {1'b0, a} + {1'b0, ~m} + {8'd0, cin};
        regs_out.p[0] = bsum[8];
        regs_out.p[6] = (a[7] ^ m[7]) & (a[7] ^ bsum[7]);
        regs_out.p[1] = (bsum[7:0] == 8'h00);
        regs_out.p[7] = bsum[7];
        if (p[3]) begin
          slo = $signed({4'd0, a[3:0]}) - $signed({4'd0, m[3:0]})
              + $signed({7'd0, cin}) - 8'sd1;
          if (slo < 0) slo = $signed({4'd0, 4'(slo[3:0] + 4'hA)}) - 8'sd16;
          shi = $signed({2'd0, a[7:4], 4'h0}) - $signed({2'd0, m[7:4], 4'h0})
              + 10'(slo);
          if (shi < 0) shi = shi - 10'sd96;
          regs_out.acc = shi[7:0];
        end else begin
          regs_out.acc = bsum[7:0];
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/cycle_exact_6502_subset_core.sv =====
// ----------------------------------------------------------------------------
// cycle_exact_6502_subset_core
// Bus-cycle-exact NMOS 6502 subset core, one bus cycle per beat.
// ----------------------------------------------------------------------------
// Each input beat is one bus cycle and carries the byte read by the access
// announced in the previous result beat; each result beat announces the next
// access and shows the registers. One beat is taken per clock unless stalled:
// the whole cycle's decode, address and ALU work sits between the state and
// result registers; a skid slot decouples the latter from the output side.
`default_nettype none
module cycle_exact_6502_subset_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_read_data,
  input  wire logic        in_restart,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_bus_addr,
  output logic             out_bus_is_write,
  output logic [7:0]       out_bus_wdata,
  output logic             out_halted,
  output logic [7:0]       out_stopped_opcode,
  output logic [7:0]       out_acc_out,
  output logic [7:0]       out_x_out,
  output logic [7:0]       out_y_out,
  output logic [7:0]       out_status_out,
  output logic [7:0]       out_sp_out,
  output logic [15:0]      out_pc_out,
  output logic             out_at_boundary
);
  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        halted;
    logic [7:0]  code;
    c6502_pkg::regs_t regs;
    logic [15:0] pc;
    logic        bound;
  } res_t;

  logic [15:0] spc_r;
  logic [7:0]  sacc_r, sx_r, sy_r, ssp_r, sst_r;
  c6502_pkg::regs_t regs_r, regs_nxt, alu_in, alu_out;
  logic [15:0] pc_r, pc_nxt, ea_r, ea_nxt;
  logic [7:0]  opc_r, opc_nxt, sb_r, sb_nxt, code_r, code_nxt;
  logic [2:0]  cyc_r, cyc_nxt;
  logic        halt_r, halt_nxt;
  logic [4:0]  alu_op;
  logic [7:0]  alu_m;
  logic        alu_en;
  c6502_pkg::dec_t dc, dn;
  logic [15:0] base, eff, nacc;
  logic [7:0]  idx, sv;
  logic        nwr;
  res_t        res, out_r, skid_r;
  logic        out_v_r, skid_v_r;
  logic        take;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~skid_v_r;
  assign take      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r <= '0; sacc_r <= '0; sx_r <= '0; sy_r <= '0;
      ssp_r <= 8'hFD; sst_r <= c6502_pkg::F_I;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        c6502_pkg::CFG_PC:     spc_r  <= cfg_data;
        c6502_pkg::CFG_ACC:    sacc_r <= cfg_data[7:0];
        c6502_pkg::CFG_X:      sx_r   <= cfg_data[7:0];
        c6502_pkg::CFG_Y:      sy_r   <= cfg_data[7:0];
        c6502_pkg::CFG_SP:     ssp_r  <= cfg_data[7:0];
        c6502_pkg::CFG_STATUS: sst_r  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign alu_in = regs_r;
  c6502_alu u_alu (.op(alu_op), .m(alu_m), .regs_in(alu_in), .regs_out(alu_out));

  always_comb begin
    dc = c6502_pkg::decode(opc_r);
    regs_nxt = regs_r; pc_nxt = pc_r; ea_nxt = ea_r; opc_nxt = opc_r;
    sb_nxt = sb_r; code_nxt = code_r; cyc_nxt = cyc_r; halt_nxt = halt_r;
    alu_op = dc.op; alu_m = in_read_data; alu_en = 1'b0;
    idx = ((dc.mode == c6502_pkg::M_ZPY) || (dc.mode == c6502_pkg::M_ABY))
          ? regs_r.y : regs_r.x;
    base = '0; eff = '0;
    if (in_restart) begin
      regs_nxt = '{acc: sacc_r, x: sx_r, y: sy_r, sp: ssp_r, p: sst_r | c6502_pkg::F_I};
      pc_nxt = spc_r; cyc_nxt = '0; halt_nxt = 1'b0;
    end else if (!halt_r) begin
      if (cyc_r == 3'd0) begin
        opc_nxt = in_read_data;
        pc_nxt = pc_r + 16'd1;
        if (c6502_pkg::decode(in_read_data).mode == c6502_pkg::M_NONE) begin
          halt_nxt = 1'b1; code_nxt = in_read_data;
        end else begin
          cyc_nxt = 3'd1;
        end
      end else begin
        cyc_nxt = '0;
        case (dc.mode)
          c6502_pkg::M_IMM: begin
            if (cyc_r == 3'd1) begin alu_en = 1'b1; pc_nxt = pc_r + 16'd1; end
          end
          c6502_pkg::M_IMPL: alu_en = (cyc_r == 3'd1);
          c6502_pkg::M_ZP: begin
            if (cyc_r == 3'd1) begin
              ea_nxt = {8'd0, in_read_data}; pc_nxt = pc_r + 16'd1; cyc_nxt = 3'd2;
            end else alu_en = 1'b1;
          end
          c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: begin
            if (cyc_r == 3'd1) begin
              ea_nxt = {8'd0, in_read_data}; pc_nxt = pc_r + 16'd1; cyc_nxt = 3'd2;
            end else if (cyc_r == 3'd2) begin
              ea_nxt = {8'd0, 8'(ea_r[7:0] + idx)}; cyc_nxt = 3'd3;
            end else alu_en = 1'b1;
          end
          c6502_pkg::M_ABS, c6502_pkg::M_ABX, c6502_pkg::M_ABY,
          c6502_pkg::M_JABS, c6502_pkg::M_JIND: begin
            if (cyc_r == 3'd1) begin
              ea_nxt = {8'd0, in_read_data}; pc_nxt = pc_r + 16'd1; cyc_nxt = 3'd2;
            end else if (cyc_r == 3'd2) begin
              if (dc.mode == c6502_pkg::M_JABS) begin
                pc_nxt = {in_read_data, ea_r[7:0]};
              end else begin
                base = {in_read_data, ea_r[7:0]};
                eff = base + ((dc.mode == c6502_pkg::M_ABS || dc.mode == c6502_pkg::M_JIND)
                              ? 16'd0 : {8'd0, idx});
                ea_nxt = eff;
                sb_nxt = {7'd0, eff[15:8] != base[15:8]};
                pc_nxt = pc_r + 16'd1; cyc_nxt = 3'd3;
              end
            end else if (dc.mode == c6502_pkg::M_JIND) begin
              if (cyc_r == 3'd3) begin sb_nxt = in_read_data; cyc_nxt = 3'd4; end
              else pc_nxt = {in_read_data, sb_r};
            end else if (dc.mode != c6502_pkg::M_ABS && cyc_r == 3'd3 &&
                         (c6502_pkg::is_store(dc.op) || sb_r != 8'd0)) begin
              cyc_nxt = 3'd4;
            end else alu_en = 1'b1;
          end
          c6502_pkg::M_INDX: begin
            if (cyc_r == 3'd1) begin
              sb_nxt = in_read_data; pc_nxt = pc_r + 16'd1; cyc_nxt = 3'd2;
            end else if (cyc_r == 3'd2) begin
              sb_nxt = sb_r + regs_r.x; cyc_nxt = 3'd3;
            end else if (cyc_r == 3'd3) begin
              ea_nxt = {8'd0, in_read_data}; cyc_nxt = 3'd4;
            end else if (cyc_r == 3'd4) begin
              ea_nxt = {in_read_data, ea_r[7:0]}; cyc_nxt = 3'd5;
            end else alu_en = 1'b1;
          end
          c6502_pkg::M_INDY: begin
            if (cyc_r == 3'd1) begin
              sb_nxt = in_read_data; pc_nxt = pc_r + 16'd1; cyc_nxt = 3'd2;
            end else if (cyc_r == 3'd2) begin
              ea_nxt = {8'd0, in_read_data}; cyc_nxt = 3'd3;
            end else if (cyc_r == 3'd3) begin
              base = {in_read_data, ea_r[7:0]};
              eff = base + {8'd0, regs_r.y};
              ea_nxt = eff;
              sb_nxt = {7'd0, eff[15:8] != base[15:8]};
              cyc_nxt = 3'd4;
            end else if (cyc_r == 3'd4 &&
                         (c6502_pkg::is_store(dc.op) || sb_r != 8'd0)) begin
              cyc_nxt = 3'd5;
            end else alu_en = 1'b1;
          end
          default: ;
        endcase
        if (alu_en && !c6502_pkg::is_store(dc.op)) regs_nxt = alu_out;
      end
    end
  end

  // Next access, from the updated state.
  always_comb begin
    dn = c6502_pkg::decode(opc_nxt);
    sv = (dn.op == c6502_pkg::OP_STA) ? regs_nxt.acc
       : ((dn.op == c6502_pkg::OP_STX) ? regs_nxt.x : regs_nxt.y);
    nacc = pc_nxt; nwr = 1'b0;
    if (!halt_nxt && cyc_nxt != 3'd0 && cyc_nxt != 3'd1) begin
      case (dn.mode)
        c6502_pkg::M_ZP: begin nacc = ea_nxt; nwr = c6502_pkg::is_store(dn.op); end
        c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: begin
          nacc = ea_nxt; nwr = (cyc_nxt != 3'd2) && c6502_pkg::is_store(dn.op);
        end
        c6502_pkg::M_ABS, c6502_pkg::M_JABS: begin
          if (cyc_nxt != 3'd2) begin nacc = ea_nxt; nwr = c6502_pkg::is_store(dn.op); end
        end
        c6502_pkg::M_ABX, c6502_pkg::M_ABY: begin
          if (cyc_nxt == 3'd3) nacc = ea_nxt - ((sb_nxt != 8'd0) ? 16'h0100 : 16'h0000);
          else if (cyc_nxt != 3'd2) begin
            nacc = ea_nxt; nwr = c6502_pkg::is_store(dn.op);
          end
        end
        c6502_pkg::M_JIND: begin
          if (cyc_nxt == 3'd3) nacc = ea_nxt;
          else if (cyc_nxt != 3'd2) nacc = {ea_nxt[15:8], 8'(ea_nxt[7:0] + 8'd1)};
        end
        c6502_pkg::M_INDX: begin
          if (cyc_nxt == 3'd2 || cyc_nxt == 3'd3) nacc = {8'd0, sb_nxt};
          else if (cyc_nxt == 3'd4) nacc = {8'd0, 8'(sb_nxt + 8'd1)};
          else begin nacc = ea_nxt; nwr = c6502_pkg::is_store(dn.op); end
        end
        c6502_pkg::M_INDY: begin
          if (cyc_nxt == 3'd2) nacc = {8'd0, sb_nxt};
          else if (cyc_nxt == 3'd3) nacc = {8'd0, 8'(sb_nxt + 8'd1)};
          else if (cyc_nxt == 3'd4)
            nacc = ea_nxt - ((sb_nxt != 8'd0) ? 16'h0100 : 16'h0000);
          else begin nacc = ea_nxt; nwr = c6502_pkg::is_store(dn.op); end
        end
        default: ;
      endcase
    end
    res.addr = nacc; res.wr = nwr; res.wdata = nwr ? sv : 8'd0;
    res.halted = halt_nxt; res.code = code_nxt; res.regs = regs_nxt;
    res.pc = pc_nxt; res.bound = !halt_nxt && (cyc_nxt == 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{acc: 8'd0, x: 8'd0, y: 8'd0, sp: 8'hFD, p: c6502_pkg::F_I};
      pc_r <= '0; ea_r <= '0; opc_r <= '0; sb_r <= '0; code_r <= '0;
      cyc_r <= '0; halt_r <= 1'b0;
    end else if (take) begin
      regs_r <= regs_nxt; pc_r <= pc_nxt; ea_r <= ea_nxt; opc_r <= opc_nxt;
      sb_r <= sb_nxt; code_r <= code_nxt; cyc_r <= cyc_nxt; halt_r <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0; skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_ready) begin
        out_v_r <= skid_v_r | take;
        skid_v_r <= 1'b0;
      end else if (take) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (take) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_bus_addr       = out_r.addr;
  assign out_bus_is_write   = out_r.wr;
  assign out_bus_wdata      = out_r.wdata;
  assign out_halted         = out_r.halted;
  assign out_stopped_opcode = out_r.code;
  assign out_acc_out        = out_r.regs.acc;
  assign out_x_out          = out_r.regs.x;
  assign out_y_out          = out_r.regs.y;
  assign out_status_out     = out_r.regs.p;
  assign out_sp_out         = out_r.regs.sp;
  assign out_pc_out         = out_r.pc;
  assign out_at_boundary    = out_r.bound;
endmodule
`default_nettype wire

// ===== dv/tb_cycle_exact_6502_subset_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycle_exact_6502_subset_core
// Self-checking bench for the cycle-exact 6502 subset core. Every bus-cycle
// beat is run through a behavioral model of the core, and each result beat
// is compared field by field. A short directed program runs first, then
// random instruction streams under several start-register settings and
// several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module tb_cycle_exact_6502_subset_core;

  localparam int RANDOM_ITEMS = 190;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        halted;
    logic [7:0]  code;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  p;
    logic [7:0]  sp;
    logic [15:0] pc;
    logic        bnd;
  } bus_beat_t;

  typedef struct {
    logic [7:0]  data;
    logic        restart;
    logic        typed;
    logic        typed_addr;
    logic [15:0] addr;
    logic        halted;
    logic        bnd;
  } program_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = c6502_pkg::CFG_PC;
  logic [15:0] cfg_data = 16'h0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_read_data = 8'h0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_bus_addr;
  logic        out_bus_is_write;
  logic [7:0]  out_bus_wdata;
  logic        out_halted;
  logic [7:0]  out_stopped_opcode;
  logic [7:0]  out_acc_out;
  logic [7:0]  out_x_out;
  logic [7:0]  out_y_out;
  logic [7:0]  out_status_out;
  logic [7:0]  out_sp_out;
  logic [15:0] out_pc_out;
  logic        out_at_boundary;

  cycle_exact_6502_subset_core DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  bus_beat_t   expected_beats[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          beat_count = 0;

  logic [15:0] boot_pc = 16'h0000;
  logic [7:0]  boot_a = 8'h00, boot_x = 8'h00, boot_y = 8'h00;
  logic [7:0]  boot_sp = 8'hFD, boot_p = 8'h04;

  logic [7:0]  cpu_a = 8'h00, cpu_x = 8'h00, cpu_y = 8'h00;
  logic [7:0]  cpu_sp = 8'hFD, cpu_p = c6502_pkg::F_I;
  logic [15:0] cpu_pc = 16'h0000;
  logic [7:0]  cpu_opcode = 8'h00;
  logic [2:0]  cpu_cycle = 3'd0;
  logic [15:0] cpu_ea = 16'h0000;
  logic [7:0]  cpu_scratch = 8'h00;
  logic        cpu_halt = 1'b0;
  logic [7:0]  cpu_halt_code = 8'h00;

  logic [7:0] other_opcodes[31] = '{
    8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE, 8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC,
    8'h86, 8'h96, 8'h8E, 8'h84, 8'h94, 8'h8C, 8'hE0, 8'hE4, 8'hEC, 8'hC0,
    8'hC4, 8'hCC, 8'hAA, 8'hA8, 8'h8A, 8'h98, 8'hBA, 8'h9A, 8'hEA, 8'h4C,
    8'h6C};

  program_row_t boot_program[28] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b1},
    '{8'hA9, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h69, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hE9, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hAA, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h9A, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hBA, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h8D, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h34, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h12, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h55, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h6C, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h10, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hCD, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hAB, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hB1, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hFE, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h12, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h5A, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h77, 1'b0, 1'b0, 1'b0, 16'h0, 1'b0, 1'b0},
    '{8'h02, 1'b0, 1'b1, 1'b0, 16'h0, 1'b1, 1'b0},
    '{8'hA9, 1'b0, 1'b1, 1'b0, 16'h0, 1'b1, 1'b0},
    '{8'h00, 1'b1, 1'b1, 1'b0, 16'h0, 1'b0, 1'b1}};

  function automatic c6502_pkg::dec_t decode_opcode(input logic [7:0] opc);
    c6502_pkg::dec_t d;
    d.mode = c6502_pkg::M_NONE;
    d.op   = c6502_pkg::OP_NOP;
    if (opc[1:0] == 2'b01 && opc != 8'h89) begin
      case (opc[7:5])
        3'd0: d.op = c6502_pkg::OP_ORA;
        3'd1: d.op = c6502_pkg::OP_AND;
        3'd2: d.op = c6502_pkg::OP_EOR;
        3'd3: d.op = c6502_pkg::OP_ADC;
        3'd4: d.op = c6502_pkg::OP_STA;
        3'd5: d.op = c6502_pkg::OP_LDA;
        3'd6: d.op = c6502_pkg::OP_CMP;
        default: d.op = c6502_pkg::OP_SBC;
      endcase
      case (opc[4:2])
        3'd0: d.mode = c6502_pkg::M_INDX;
        3'd1: d.mode = c6502_pkg::M_ZP;
        3'd2: d.mode = c6502_pkg::M_IMM;
        3'd3: d.mode = c6502_pkg::M_ABS;
        3'd4: d.mode = c6502_pkg::M_INDY;
        3'd5: d.mode = c6502_pkg::M_ZPX;
        3'd6: d.mode = c6502_pkg::M_ABY;
        default: d.mode = c6502_pkg::M_ABX;
      endcase
    end else if (opc[1:0] != 2'b01) begin
      case (opc)
        8'hA2: d = '{c6502_pkg::M_IMM, c6502_pkg::OP_LDX};
        8'hA6: d = '{c6502_pkg::M_ZP, c6502_pkg::OP_LDX};
        8'hB6: d = '{c6502_pkg::M_ZPY, c6502_pkg::OP_LDX};
        8'hAE: d = '{c6502_pkg::M_ABS, c6502_pkg::OP_LDX};
        8'hBE: d = '{c6502_pkg::M_ABY, c6502_pkg::OP_LDX};
        8'hA0: d = '{c6502_pkg::M_IMM, c6502_pkg::OP_LDY};
        8'hA4: d = '{c6502_pkg::M_ZP, c6502_pkg::OP_LDY};
        8'hB4: d = '{c6502_pkg::M_ZPX, c6502_pkg::OP_LDY};
        8'hAC: d = '{c6502_pkg::M_ABS, c6502_pkg::OP_LDY};
        8'hBC: d = '{c6502_pkg::M_ABX, c6502_pkg::OP_LDY};
        8'h86: d = '{c6502_pkg::M_ZP, c6502_pkg::OP_STX};
        8'h96: d = '{c6502_pkg::M_ZPY, c6502_pkg::OP_STX};
        8'h8E: d = '{c6502_pkg::M_ABS, c6502_pkg::OP_STX};
        8'h84: d = '{c6502_pkg::M_ZP, c6502_pkg::OP_STY};
        8'h94: d = '{c6502_pkg::M_ZPX, c6502_pkg::OP_STY};
        8'h8C: d = '{c6502_pkg::M_ABS, c6502_pkg::OP_STY};
        8'hE0: d = '{c6502_pkg::M_IMM, c6502_pkg::OP_CPX};
        8'hE4: d = '{c6502_pkg::M_ZP, c6502_pkg::OP_CPX};
        8'hEC: d = '{c6502_pkg::M_ABS, c6502_pkg::OP_CPX};
        8'hC0: d = '{c6502_pkg::M_IMM, c6502_pkg::OP_CPY};
        8'hC4: d = '{c6502_pkg::M_ZP, c6502_pkg::OP_CPY};
        8'hCC: d = '{c6502_pkg::M_ABS, c6502_pkg::OP_CPY};
        8'hAA: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_TAX};
        8'hA8: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_TAY};
        8'h8A: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_TXA};
        8'h98: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_TYA};
        8'hBA: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_TSX};
        8'h9A: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_TXS};
        8'hEA: d = '{c6502_pkg::M_IMPL, c6502_pkg::OP_NOP};
        8'h4C: d = '{c6502_pkg::M_JABS, c6502_pkg::OP_JMP};
        8'h6C: d = '{c6502_pkg::M_JIND, c6502_pkg::OP_JMP};
        default: d.mode = c6502_pkg::M_NONE;
      endcase
    end
    return d;
  endfunction

  function automatic logic writes_memory(input logic [4:0] op);
    return op == c6502_pkg::OP_STA || op == c6502_pkg::OP_STX || op == c6502_pkg::OP_STY;
  endfunction

  task automatic set_flag(input logic [7:0] mask, input logic on);
    cpu_p = on ? (cpu_p | mask) : (cpu_p & ~mask);
  endtask

  task automatic set_nz(input logic [7:0] v);
    set_flag(c6502_pkg::F_Z, v == 8'h00);
    set_flag(c6502_pkg::F_N, v[7]);
  endtask

  task automatic compare_reg(input logic [7:0] r, input logic [7:0] m);
    set_flag(c6502_pkg::F_C, r >= m);
    set_nz(r - m);
  endtask

  task automatic add_with_carry(input logic [7:0] m);
    int a, mi, cin, lo, hi, sum;
    a = cpu_a;
    mi = m;
    cin = cpu_p[0];
    if (cpu_p & c6502_pkg::F_D) begin
      set_flag(c6502_pkg::F_Z, ((a + mi + cin) & 8'hFF) == 0);
      lo = (a & 'h0F) + (mi & 'h0F) + cin;
      if (lo >= 'h0A) lo = ((lo + 'h06) & 'h0F) + 'h10;
      hi = (a & 'hF0) + (mi & 'hF0) + lo;
      set_flag(c6502_pkg::F_N, (hi & 'h80) != 0);
      set_flag(c6502_pkg::F_V, (~(a ^ mi) & (a ^ hi) & 'h80) != 0);
      if (hi >= 'hA0) hi += 'h60;
      set_flag(c6502_pkg::F_C, hi >= 'h100);
      cpu_a = hi[7:0];
    end else begin
      sum = a + mi + cin;
      set_flag(c6502_pkg::F_C, sum > 'hFF);
      set_flag(c6502_pkg::F_V, (~(a ^ mi) & (a ^ sum) & 'h80) != 0);
      cpu_a = sum[7:0];
      set_nz(cpu_a);
    end
  endtask

  task automatic subtract_with_borrow(input logic [7:0] m);
    int a, mi, cin, sum, bin, lo, hi;
    a = cpu_a;
    mi = m;
    cin = cpu_p[0];
    sum = a + (mi ^ 'hFF) + cin;
    bin = sum & 'hFF;
    set_flag(c6502_pkg::F_C, sum > 'hFF);
    set_flag(c6502_pkg::F_V, ((a ^ mi) & (a ^ bin) & 'h80) != 0);
    set_nz(bin[7:0]);
    if (cpu_p & c6502_pkg::F_D) begin
      lo = (a & 'h0F) - (mi & 'h0F) + cin - 1;
      if (lo < 0) lo = ((lo + 26) & 'h0F) - 'h10;
      hi = (a & 'hF0) - (mi & 'hF0) + lo;
      if (hi < 0) hi -= 'h60;
      cpu_a = hi[7:0];
    end else begin
      cpu_a = bin[7:0];
    end
  endtask

  task automatic execute_op(input logic [4:0] op, input logic [7:0] m);
    case (op)
      c6502_pkg::OP_LDA: begin cpu_a = m; set_nz(m); end
      c6502_pkg::OP_LDX: begin cpu_x = m; set_nz(m); end
      c6502_pkg::OP_LDY: begin cpu_y = m; set_nz(m); end
      c6502_pkg::OP_AND: begin cpu_a &= m; set_nz(cpu_a); end
      c6502_pkg::OP_ORA: begin cpu_a |= m; set_nz(cpu_a); end
      c6502_pkg::OP_EOR: begin cpu_a ^= m; set_nz(cpu_a); end
      c6502_pkg::OP_CMP: compare_reg(cpu_a, m);
      c6502_pkg::OP_CPX: compare_reg(cpu_x, m);
      c6502_pkg::OP_CPY: compare_reg(cpu_y, m);
      c6502_pkg::OP_ADC: add_with_carry(m);
      c6502_pkg::OP_SBC: subtract_with_borrow(m);
      c6502_pkg::OP_TAX: begin cpu_x = cpu_a; set_nz(cpu_x); end
      c6502_pkg::OP_TAY: begin cpu_y = cpu_a; set_nz(cpu_y); end
      c6502_pkg::OP_TXA: begin cpu_a = cpu_x; set_nz(cpu_a); end
      c6502_pkg::OP_TYA: begin cpu_a = cpu_y; set_nz(cpu_a); end
      c6502_pkg::OP_TSX: begin cpu_x = cpu_sp; set_nz(cpu_x); end
      c6502_pkg::OP_TXS: cpu_sp = cpu_x;
      default: ;
    endcase
  endtask

  task automatic last_operand_cycle(input logic [4:0] op, input logic [7:0] m);
    if (!writes_memory(op)) execute_op(op, m);
    cpu_cycle = 3'd0;
  endtask

  task automatic index_base(input logic [7:0] hi, input logic [7:0] idx);
    logic [15:0] base;
    base = {hi, cpu_ea[7:0]};
    cpu_ea = base + {8'h00, idx};
    cpu_scratch = (cpu_ea[15:8] != base[15:8]) ? 8'h01 : 8'h00;
  endtask

  task automatic run_bus_cycle(input logic [7:0] data);
    c6502_pkg::dec_t d;
    logic [2:0] c;
    logic [7:0] idx;
    c = cpu_cycle;
    if (c == 3'd0) begin
      cpu_opcode = data;
      cpu_pc++;
      if (decode_opcode(data).mode == c6502_pkg::M_NONE) begin
        cpu_halt = 1'b1;
        cpu_halt_code = data;
        cpu_cycle = 3'd0;
      end else begin
        cpu_cycle = 3'd1;
      end
      return;
    end
    d = decode_opcode(cpu_opcode);
    idx = (d.mode == c6502_pkg::M_ZPY || d.mode == c6502_pkg::M_ABY) ? cpu_y : cpu_x;
    case (d.mode)
      c6502_pkg::M_IMM: begin
        if (c == 3'd1) begin execute_op(d.op, data); cpu_pc++; end
        cpu_cycle = 3'd0;
      end
      c6502_pkg::M_IMPL: begin
        if (c == 3'd1) execute_op(d.op, data);
        cpu_cycle = 3'd0;
      end
      c6502_pkg::M_ZP: begin
        if (c == 3'd1) begin cpu_ea = {8'h00, data}; cpu_pc++; cpu_cycle = 3'd2; end
        else last_operand_cycle(d.op, data);
      end
      c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: begin
        if (c == 3'd1) begin cpu_ea = {8'h00, data}; cpu_pc++; cpu_cycle = 3'd2; end
        else if (c == 3'd2) begin
          cpu_ea = {8'h00, cpu_ea[7:0] + idx};
          cpu_cycle = 3'd3;
        end else last_operand_cycle(d.op, data);
      end
      c6502_pkg::M_ABS, c6502_pkg::M_ABX, c6502_pkg::M_ABY, c6502_pkg::M_JABS,
      c6502_pkg::M_JIND: begin
        if (c == 3'd1) begin
          cpu_ea = {8'h00, data};
          cpu_pc++;
          cpu_cycle = 3'd2;
        end else if (c == 3'd2) begin
          if (d.mode == c6502_pkg::M_JABS) begin
            cpu_pc = {data, cpu_ea[7:0]};
            cpu_cycle = 3'd0;
          end else begin
            index_base(data, (d.mode == c6502_pkg::M_ABS || d.mode == c6502_pkg::M_JIND)
                             ? 8'h00 : idx);
            cpu_pc++;
            cpu_cycle = 3'd3;
          end
        end else if (d.mode == c6502_pkg::M_JIND) begin
          if (c == 3'd3) begin cpu_scratch = data; cpu_cycle = 3'd4; end
          else begin cpu_pc = {data, cpu_scratch}; cpu_cycle = 3'd0; end
        end else if (d.mode != c6502_pkg::M_ABS && c == 3'd3 &&
                     (writes_memory(d.op) || cpu_scratch != 8'h00)) begin
          cpu_cycle = 3'd4;
        end else last_operand_cycle(d.op, data);
      end
      c6502_pkg::M_INDX: begin
        if (c == 3'd1) begin cpu_scratch = data; cpu_pc++; cpu_cycle = 3'd2; end
        else if (c == 3'd2) begin cpu_scratch += cpu_x; cpu_cycle = 3'd3; end
        else if (c == 3'd3) begin cpu_ea = {8'h00, data}; cpu_cycle = 3'd4; end
        else if (c == 3'd4) begin cpu_ea = {data, cpu_ea[7:0]}; cpu_cycle = 3'd5; end
        else last_operand_cycle(d.op, data);
      end
      c6502_pkg::M_INDY: begin
        if (c == 3'd1) begin cpu_scratch = data; cpu_pc++; cpu_cycle = 3'd2; end
        else if (c == 3'd2) begin cpu_ea = {8'h00, data}; cpu_cycle = 3'd3; end
        else if (c == 3'd3) begin index_base(data, cpu_y); cpu_cycle = 3'd4; end
        else if (c == 3'd4 && (writes_memory(d.op) || cpu_scratch != 8'h00))
          cpu_cycle = 3'd5;
        else last_operand_cycle(d.op, data);
      end
      default: cpu_cycle = 3'd0;
    endcase
  endtask

  task automatic announce_access(output bus_beat_t e);
    c6502_pkg::dec_t d;
    logic [2:0] c;
    logic [15:0] back;
    logic operand;
    c = cpu_cycle;
    back = (cpu_scratch != 8'h00) ? 16'h0100 : 16'h0000;
    d = decode_opcode(cpu_opcode);
    operand = 1'b0;
    e.addr = cpu_pc;
    e.wr = 1'b0;
    e.wdata = 8'h00;
    if (!cpu_halt && c > 3'd1) begin
      case (d.mode)
        c6502_pkg::M_ZP: operand = 1'b1;
        c6502_pkg::M_ZPX, c6502_pkg::M_ZPY: if (c == 3'd2) e.addr = cpu_ea; else operand = 1'b1;
        c6502_pkg::M_ABS, c6502_pkg::M_JABS: if (c != 3'd2) operand = 1'b1;
        c6502_pkg::M_ABX, c6502_pkg::M_ABY: begin
          if (c == 3'd3) e.addr = cpu_ea - back;
          else if (c != 3'd2) operand = 1'b1;
        end
        c6502_pkg::M_JIND: begin
          if (c == 3'd3) e.addr = cpu_ea;
          else if (c != 3'd2) e.addr = {cpu_ea[15:8], cpu_ea[7:0] + 8'h01};
        end
        c6502_pkg::M_INDX: begin
          if (c == 3'd2 || c == 3'd3) e.addr = {8'h00, cpu_scratch};
          else if (c == 3'd4) e.addr = {8'h00, cpu_scratch + 8'h01};
          else operand = 1'b1;
        end
        c6502_pkg::M_INDY: begin
          if (c == 3'd2) e.addr = {8'h00, cpu_scratch};
          else if (c == 3'd3) e.addr = {8'h00, cpu_scratch + 8'h01};
          else if (c == 3'd4) e.addr = cpu_ea - back;
          else operand = 1'b1;
        end
        default: ;
      endcase
    end
    if (operand) begin
      e.addr = cpu_ea;
      if (writes_memory(d.op)) begin
        e.wr = 1'b1;
        e.wdata = (d.op == c6502_pkg::OP_STA) ? cpu_a
                : ((d.op == c6502_pkg::OP_STX) ? cpu_x : cpu_y);
      end
    end
    e.halted = cpu_halt;
    e.code = cpu_halt_code;
    e.a = cpu_a;
    e.x = cpu_x;
    e.y = cpu_y;
    e.p = cpu_p;
    e.sp = cpu_sp;
    e.pc = cpu_pc;
    e.bnd = !cpu_halt && cpu_cycle == 3'd0;
  endtask

  task automatic predict_bus_cycle(input logic [7:0] data, input logic restart);
    bus_beat_t e;
    if (restart) begin
      cpu_a = boot_a;
      cpu_x = boot_x;
      cpu_y = boot_y;
      cpu_sp = boot_sp;
      cpu_p = boot_p | c6502_pkg::F_I;
      cpu_pc = boot_pc;
      cpu_cycle = 3'd0;
      cpu_halt = 1'b0;
    end else if (!cpu_halt) begin
      run_bus_cycle(data);
    end
    announce_access(e);
    expected_beats.push_back(e);
  endtask

  task automatic send_bus_cycle(input logic [7:0] data, input logic restart);
    in_valid <= 1'b1;
    in_read_data <= data;
    in_restart <= restart;
    do @(posedge clk); while (!(in_valid && in_ready));
    predict_bus_cycle(data, restart);
    beat_count++;
    if (send_idle_pct > 0 && (beat_count % 64) < 48 &&
        $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic write_start_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      c6502_pkg::CFG_PC: boot_pc = value;
      c6502_pkg::CFG_ACC: boot_a = value[7:0];
      c6502_pkg::CFG_X: boot_x = value[7:0];
      c6502_pkg::CFG_Y: boot_y = value[7:0];
      c6502_pkg::CFG_SP: boot_sp = value[7:0];
      default: boot_p = value[7:0];
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic load_start_regs(input logic [15:0] pc, input logic [7:0] a,
                                 input logic [7:0] x, input logic [7:0] y,
                                 input logic [7:0] sp, input logic [7:0] p);
    drain_results();
    write_start_reg(c6502_pkg::CFG_PC, pc);
    write_start_reg(c6502_pkg::CFG_ACC, {8'h00, a});
    write_start_reg(c6502_pkg::CFG_X, {8'h00, x});
    write_start_reg(c6502_pkg::CFG_Y, {8'h00, y});
    write_start_reg(c6502_pkg::CFG_SP, {8'h00, sp});
    write_start_reg(c6502_pkg::CFG_STATUS, {8'h00, p});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] opc;
    if ($urandom_range(99) < 12) return 8'($urandom);
    if ($urandom_range(1) == 0) begin
      opc = {3'($urandom), 3'($urandom), 2'b01};
      return (opc == 8'h89) ? 8'hA9 : opc;
    end
    return other_opcodes[$urandom_range(30)];
  endfunction

  task automatic run_random_stream(input int count);
    logic [7:0] data;
    logic restart;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        in_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge clk);
      end
      restart = cpu_halt ? ($urandom_range(3) == 0) : ($urandom_range(99) < 2);
      if (!restart && !cpu_halt && cpu_cycle == 3'd0) data = pick_opcode();
      else data = 8'($urandom);
      send_bus_cycle(data, restart);
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] exp_v,
                                      input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    bus_beat_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        error_count++;
        $display("%0t ns: result beat with none expected, expected none, actual addr %h",
                 $time, out_bus_addr);
      end else begin
        e = expected_beats.pop_front();
        check_field("bus_addr", e.addr, out_bus_addr);
        check_field("bus_is_write", 16'(e.wr), 16'(out_bus_is_write));
        check_field("bus_wdata", 16'(e.wdata), 16'(out_bus_wdata));
        check_field("halted", 16'(e.halted), 16'(out_halted));
        check_field("stopped_opcode", 16'(e.code), 16'(out_stopped_opcode));
        check_field("acc", 16'(e.a), 16'(out_acc_out));
        check_field("x", 16'(e.x), 16'(out_x_out));
        check_field("y", 16'(e.y), 16'(out_y_out));
        check_field("status", 16'(e.p), 16'(out_status_out));
        check_field("sp", 16'(e.sp), 16'(out_sp_out));
        check_field("pc", e.pc, out_pc_out);
        check_field("at_boundary", 16'(e.bnd), 16'(out_at_boundary));
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= (recv_stall_pct == 0) || (cycle_count % 512) >= 400 ||
                 ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(boot_program); i++) begin
      send_bus_cycle(boot_program[i].data, boot_program[i].restart);
      if (boot_program[i].typed) begin
        if (boot_program[i].typed_addr) expected_beats[$].addr = boot_program[i].addr;
        expected_beats[$].halted = boot_program[i].halted;
        expected_beats[$].bnd = boot_program[i].bnd;
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: load_start_regs(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1: load_start_regs(16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        2: load_start_regs(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 8'h08);
        default: load_start_regs(16'($urandom), 8'($urandom), 8'($urandom),
                                 8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      send_idle_pct = (phase == 1) ? 83 : ((phase == 3) ? 18 : 0);
      recv_stall_pct = (phase == 2) ? 83 : ((phase == 3) ? 18 : 0);
      send_bus_cycle(8'($urandom), 1'b1);
      run_random_stream(RANDOM_ITEMS);
    end

    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== cycle_exact_6502_subset_core.f =====
rtl/c6502_pkg.sv
rtl/c6502_alu.sv
rtl/cycle_exact_6502_subset_core.sv
dv/tb_cycle_exact_6502_subset_core.sv
